### sv/fwid_pkg.sv
package fwid_pkg;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ     = 2'd1,
        OP_DISCARD = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    // per-cycle command broadcast along the row of cells
    typedef struct packed {
        logic enq;
        logic shift;
    } cell_ctl_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;

endpackage

### sv/fwid_cell.sv
module fwid_cell #(
    parameter int unsigned ELEM_WIDTH = 32,
    parameter int unsigned CNT_W      = 5,
    parameter int unsigned IDX        = 0
) (
    input  logic                  clk,
    input  fwid_pkg::cell_ctl_t   ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [CNT_W-1:0]      rm_idx,
    input  logic [ELEM_WIDTH-1:0] in_value,
    input  logic [ELEM_WIDTH-1:0] neighbour_value,
    output logic [ELEM_WIDTH-1:0] value,
    output logic [ELEM_WIDTH-1:0] value_next
);
    import fwid_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [ELEM_WIDTH-1:0] value_reg;

    always_comb
    begin
        value_next = value_reg;
        priority if (ctl.enq && (count == MY_IDX))
        begin
            value_next = in_value;
        end
        else if (ctl.shift && (MY_IDX >= rm_idx))
        begin
            // close the gap: take the entry from the tail side
            value_next = neighbour_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### sv/fifo_with_indexed_discard_top.sv
// registered: the result of an accepted input beat appears on m_tdata in the cycle after it is accepted
// throughput: one beat per cycle unless a held result stalls on m_tready; all cells shift in parallel in the same cycle
// the output register takes a new result whenever it is empty or being drained
// reset: entry count and output valid cleared asynchronously
// stored entries have no reset and are only read after being written
module fifo_with_indexed_discard_top #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // elem_value[31:0], position[35:32], zero pad
    input  logic [fwid_pkg::IN_TDATA_W-1:0]      s_tdata,
    // func[1:0]
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // head_value[31:0], entry_count[36:32], is_empty[37], op_error[38], zero pad
    output logic [fwid_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import fwid_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic                  accept;
    op_t                   op;
    logic [VALUE_W-1:0]    value_u;
    logic [POS_W-1:0]      pos;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      count_cmp;
    logic [ELEM_WIDTH-1:0] in_value;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] rm_idx;
    logic             op_err;
    cell_ctl_t        ctl;

    logic [ELEM_WIDTH-1:0] cell_value [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_next  [DEPTH];

    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     out_head_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_empty_reg;
    logic                   out_err_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign op        = op_t'(s_tuser);
    assign value_u   = s_tdata[VALUE_W-1:0];
    assign pos       = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign pos_cmp   = CMP_W'(pos);
    assign count_cmp = CMP_W'(count_reg);
    assign in_value  = ELEM_WIDTH'(value_u);

    always_comb
    begin
        op_err = 1'b0;
        ctl    = '0;
        rm_idx = '0;
        unique case (op)
            OP_ENQ:
            begin
                op_err  = (count_reg >= FULL_COUNT);
                ctl.enq = !op_err;
            end
            OP_DEQ:
            begin
                op_err    = (count_reg == '0);
                ctl.shift = !op_err;
            end
            OP_DISCARD:
            begin
                op_err    = (pos_cmp >= count_cmp);
                ctl.shift = !op_err;
                rm_idx    = CNT_W'(pos_cmp);
            end
            default:
            begin
                op_err = 1'b1;
            end
        endcase
        if (!accept)
        begin
            ctl = '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.shift)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fwid_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .clk             (clk),
            .ctl             (ctl),
            .count           (count_reg),
            .rm_idx          (rm_idx),
            .in_value        (in_value),
            .neighbour_value (cell_value[(i + 1 < DEPTH) ? i + 1 : i]),
            .value           (cell_value[i]),
            .value_next      (cell_next[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_head_reg  <= (count_next == '0) ? '0 : VALUE_W'(cell_next[0]);
            out_count_reg <= COUNT_W'(count_next);
            out_empty_reg <= (count_next == '0);
            out_err_reg   <= op_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_err_reg, out_empty_reg, out_count_reg, out_head_reg};

    property p_count_bounded;
        @(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT;
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("entry count beyond depth");

    property p_err_keeps_count;
        @(posedge clk) disable iff (!rst_n) (accept && op_err) |=> $stable(count_reg);
    endproperty
    a_err_keeps_count: assert property (p_err_keeps_count)
        else $error("rejected request changed the count");

    property p_enq_grows;
        @(posedge clk) disable iff (!rst_n)
            (accept && (op == OP_ENQ) && !op_err) |=> (count_reg == $past(count_reg) + 1'b1);
    endproperty
    a_enq_grows: assert property (p_enq_grows)
        else $error("enqueue did not add an entry");

endmodule
